// File: rtl/mcmf_pkg.sv
// Package for the MIDI channel message filter: payload structs, the per-channel
// table entry, command and message codes, the controller FSM states and scaling constants.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mcmf_pkg;

    // One input transfer.
    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] kind;
        logic [3:0] channel;
        logic       all_channels;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       enable;
        logic [6:0] patch;
        logic [7:0] volume_percent;
    } item_t;

    // One output transfer.
    typedef struct packed {
        logic [2:0] out_kind;
        logic [3:0] out_channel;
        logic [6:0] out_first;
        logic [6:0] out_second;
        logic       last;
    } result_t;

    // Per-channel state held in the channel table.
    typedef struct packed {
        logic       mute;
        logic       lock;
        logic [6:0] locked_prog;
        logic [6:0] last_prog;
        logic [6:0] stored_vol;
        logic [7:0] vol_scale;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        mute:        1'b0,
        lock:        1'b0,
        locked_prog: 7'd0,
        last_prog:   7'd0,
        stored_vol:  7'd100,
        vol_scale:   8'd100
    };

    // Table write request produced by the transform.
    typedef struct packed {
        logic   en;
        entry_t entry;
    } tbl_wr_t;

    // Transform outcome carried into the output stage.
    typedef struct packed {
        logic        emit;    // one result to send
        logic        pair;    // an all-sounds-off result follows
        logic        scaled;  // second byte comes from the volume product
        logic [14:0] prod;    // value times percent
        result_t     res;
    } xf_t;

    typedef enum logic [2:0] {
        CMD_MESSAGE = 3'd0,
        CMD_MUTE    = 3'd1,
        CMD_LOCK    = 3'd2,
        CMD_PATCH   = 3'd3,
        CMD_VOLUME  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_OUT,
        ST_EMIT2
    } state_t;

    localparam logic [2:0] KIND_NOTEOFF   = 3'd0;
    localparam logic [2:0] KIND_NOTEON    = 3'd1;
    localparam logic [2:0] KIND_KEYPRESS  = 3'd2;
    localparam logic [2:0] KIND_CONTROL   = 3'd3;
    localparam logic [2:0] KIND_PROGRAM   = 3'd4;
    localparam logic [2:0] KIND_CHANPRESS = 3'd5;
    localparam logic [2:0] KIND_BEND      = 3'd6;

    localparam logic [3:0] DRUM_CHANNEL       = 4'd9;
    localparam logic [6:0] CTL_MAIN_VOLUME    = 7'd7;
    localparam logic [6:0] CTL_ALL_SOUNDS_OFF = 7'd120;
    localparam logic [6:0] CTL_ALL_NOTES_OFF  = 7'd123;
    localparam logic [6:0] DATA_MAX           = 7'd127;

    // floor(x / 100) equals (x * SCALE_RECIP) >> SCALE_SHIFT for every x below 43690.
    localparam logic [15:0] SCALE_RECIP = 16'd41944;
    localparam int          SCALE_SHIFT = 22;

endpackage

// File: rtl/mcmf_table.sv
// Per-channel state table: a synchronous memory with a registered read,
// plus one valid bit per channel so unwritten entries read as their reset value.
// Depends on mcmf_pkg.
`timescale 1ns / 1ps

module mcmf_table #(
    parameter int CHANNELS = 16,
    parameter int CH_W     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [CH_W-1:0]     rd_addr,
    input  mcmf_pkg::tbl_wr_t   wr,
    input  logic [CH_W-1:0]     wr_addr,
    output mcmf_pkg::entry_t    rd_entry
);

    mcmf_pkg::entry_t mem_reg [CHANNELS];
    mcmf_pkg::entry_t rd_data_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr_addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : mcmf_pkg::RESET_ENTRY;

endmodule

// File: rtl/mcmf_xform.sv
// Message and command transform: from the latched item and the channel's table
// entry it forms the table write-back and the first result of the item.
// Depends on mcmf_pkg.
`timescale 1ns / 1ps

module mcmf_xform #(
    parameter int CHANNELS = 16,
    parameter int CH_W     = 4
) (
    input  mcmf_pkg::item_t     item,
    input  mcmf_pkg::entry_t    entry,
    input  logic signed [6:0]   pitch_shift,
    input  logic [CH_W-1:0]     cur_addr,
    output mcmf_pkg::tbl_wr_t   wr,
    output mcmf_pkg::xf_t       xf
);

    logic              ch_ok;
    logic              sweep;
    logic signed [8:0] key_sum;
    logic [6:0]        key_out;
    logic [6:0]        mul_v;
    logic [7:0]        mul_pct;

    assign ch_ok = {1'b0, item.channel} < 5'(CHANNELS);
    assign sweep = (item.cmd == mcmf_pkg::CMD_VOLUME) && item.all_channels;

    // Key transpose with saturation; the drum channel is left alone.
    assign key_sum = $signed({2'b00, item.data_first})
                   + $signed({{2{pitch_shift[6]}}, pitch_shift});

    always_comb
    begin
        if (item.channel == mcmf_pkg::DRUM_CHANNEL)
        begin
            key_out = item.data_first;
        end
        else if (key_sum < 0)
        begin
            key_out = 7'd0;
        end
        else if (key_sum > $signed({2'b00, mcmf_pkg::DATA_MAX}))
        begin
            key_out = mcmf_pkg::DATA_MAX;
        end
        else
        begin
            key_out = key_sum[6:0];
        end
    end

    // A controller message scales its own value by the stored percent; set volume
    // scales the stored value by the new percent.
    always_comb
    begin
        if (item.cmd == mcmf_pkg::CMD_VOLUME)
        begin
            mul_v   = entry.stored_vol;
            mul_pct = item.volume_percent;
        end
        else
        begin
            mul_v   = item.data_second;
            mul_pct = entry.vol_scale;
        end
    end

    always_comb
    begin
        wr.en    = 1'b0;
        wr.entry = entry;
        xf.emit   = 1'b0;
        xf.pair   = 1'b0;
        xf.scaled = 1'b0;
        xf.prod   = {8'd0, mul_v} * {7'd0, mul_pct};
        xf.res.out_kind    = item.kind;
        xf.res.out_channel = item.channel;
        xf.res.out_first   = item.data_first;
        xf.res.out_second  = item.data_second;
        xf.res.last        = 1'b1;

        unique case (item.cmd)
            mcmf_pkg::CMD_MESSAGE:
            begin
                if (ch_ok && !entry.mute)
                begin
                    unique case (item.kind)
                        mcmf_pkg::KIND_NOTEOFF, mcmf_pkg::KIND_NOTEON,
                        mcmf_pkg::KIND_KEYPRESS:
                        begin
                            xf.emit          = 1'b1;
                            xf.res.out_first = key_out;
                        end
                        mcmf_pkg::KIND_CONTROL:
                        begin
                            xf.emit = 1'b1;
                            if (item.data_first == mcmf_pkg::CTL_MAIN_VOLUME)
                            begin
                                wr.en               = 1'b1;
                                wr.entry.stored_vol = item.data_second;
                                xf.scaled           = 1'b1;
                            end
                        end
                        mcmf_pkg::KIND_PROGRAM:
                        begin
                            xf.emit           = 1'b1;
                            xf.res.out_second = 7'd0;
                            wr.en             = 1'b1;
                            if (entry.lock)
                            begin
                                xf.res.out_first   = entry.locked_prog;
                                wr.entry.last_prog = entry.locked_prog;
                            end
                            else
                            begin
                                wr.entry.last_prog = item.data_first;
                            end
                        end
                        mcmf_pkg::KIND_CHANPRESS:
                        begin
                            xf.emit           = 1'b1;
                            xf.res.out_second = 7'd0;
                        end
                        mcmf_pkg::KIND_BEND:
                        begin
                            xf.emit = 1'b1;
                        end
                        default:
                        begin
                            xf.emit = 1'b0;
                        end
                    endcase
                end
            end
            mcmf_pkg::CMD_MUTE:
            begin
                if (ch_ok && (entry.mute != item.enable))
                begin
                    wr.en         = 1'b1;
                    wr.entry.mute = item.enable;
                    if (item.enable)
                    begin
                        xf.emit            = 1'b1;
                        xf.pair            = 1'b1;
                        xf.res.out_kind    = mcmf_pkg::KIND_CONTROL;
                        xf.res.out_first   = mcmf_pkg::CTL_ALL_NOTES_OFF;
                        xf.res.out_second  = 7'd0;
                        xf.res.last        = 1'b0;
                    end
                end
            end
            mcmf_pkg::CMD_LOCK:
            begin
                if (ch_ok && (entry.lock != item.enable))
                begin
                    wr.en         = 1'b1;
                    wr.entry.lock = item.enable;
                    if (item.enable)
                    begin
                        wr.entry.locked_prog = entry.last_prog;
                    end
                end
            end
            mcmf_pkg::CMD_PATCH:
            begin
                if (ch_ok)
                begin
                    wr.en              = 1'b1;
                    wr.entry.last_prog = item.patch;
                    if (entry.lock)
                    begin
                        wr.entry.locked_prog = item.patch;
                    end
                end
            end
            mcmf_pkg::CMD_VOLUME:
            begin
                if (sweep || ch_ok)
                begin
                    wr.en              = 1'b1;
                    wr.entry.vol_scale = item.volume_percent;
                    xf.emit            = 1'b1;
                    xf.scaled          = 1'b1;
                    xf.res.out_kind    = mcmf_pkg::KIND_CONTROL;
                    xf.res.out_first   = mcmf_pkg::CTL_MAIN_VOLUME;
                    if (sweep)
                    begin
                        xf.res.out_channel = 4'(cur_addr);
                        xf.res.last        = (cur_addr == CH_W'(CHANNELS - 1));
                    end
                end
            end
            default:
            begin
                xf.emit = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/midi_channel_message_filter.sv
// Flow: an accepted item has its table entry read, is transformed and written back in the
// transform state, and puts its first result in the output register in the output state.
// A new item is taken when idle or in the output state that ends the last one; a mute that emits
// two results adds a second output state, and set volume for all repeats both per channel.
// Reset: asynchronous, active low; clears control state, the pitch shift and the
// table's valid bits, so every channel reads as unmuted, unlocked, program 0, volume 100.
`timescale 1ns / 1ps

module midi_channel_message_filter #(
    parameter int CHANNELS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  mcmf_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output mcmf_pkg::result_t   result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_ADDR = CH_W'(CHANNELS - 1);

    // Pitch shift register, to be written only while the block is idle; not enforced.
    logic signed [6:0] pitch_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_shift_reg <= 7'sd0;
        end
        else if (cfg_wr_en)
        begin
            pitch_shift_reg <= $signed(cfg_wr_data);
        end
    end

    // Controller state.
    mcmf_pkg::state_t  state_reg, state_next;
    logic [CH_W-1:0]   cur_addr_reg, cur_addr_next;
    mcmf_pkg::item_t   item_reg;
    mcmf_pkg::xf_t     xf_reg;
    logic              res_valid_reg, res_valid_next;
    mcmf_pkg::result_t res_reg, res_next;

    logic              accept;
    logic              out_free;
    logic              is_sweep;
    logic              sweep_more;
    logic              go;
    logic              tbl_rd_en;
    logic [CH_W-1:0]   tbl_rd_addr;
    mcmf_pkg::entry_t  entry;
    mcmf_pkg::tbl_wr_t tbl_wr;
    mcmf_pkg::tbl_wr_t xf_wr;
    mcmf_pkg::xf_t     xf;
    logic [30:0]       q_full;
    logic [8:0]        quot;
    logic [6:0]        scaled_vol;

    mcmf_table #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .wr       (tbl_wr),
        .wr_addr  (cur_addr_reg),
        .rd_entry (entry)
    );

    mcmf_xform #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_xform (
        .item        (item_reg),
        .entry       (entry),
        .pitch_shift (pitch_shift_reg),
        .cur_addr    (cur_addr_reg),
        .wr          (xf_wr),
        .xf          (xf)
    );

    // The table is written back only in the transform cycle, which is never a cycle
    // that reads the same entry.
    always_comb
    begin
        tbl_wr    = xf_wr;
        tbl_wr.en = xf_wr.en && (state_reg == mcmf_pkg::ST_PROC);
    end

    // Volume scaling finishes here: the product was registered in the transform cycle,
    // the divide by 100 is a multiply by a fixed reciprocal, then a clamp at 127.
    assign q_full     = {16'd0, xf_reg.prod} * 31'(mcmf_pkg::SCALE_RECIP);
    assign quot       = q_full[mcmf_pkg::SCALE_SHIFT +: 9];
    assign scaled_vol = (quot > 9'(mcmf_pkg::DATA_MAX)) ? mcmf_pkg::DATA_MAX : quot[6:0];

    assign out_free   = !res_valid_reg || !result_stall;
    assign is_sweep   = (item_reg.cmd == mcmf_pkg::CMD_VOLUME) && item_reg.all_channels;
    assign sweep_more = is_sweep && (cur_addr_reg != LAST_ADDR);
    assign go         = !xf_reg.emit || out_free;

    // A new item is taken when idle, or in the output cycle that finishes the last one.
    assign item_stall = !((state_reg == mcmf_pkg::ST_IDLE)
                       || ((state_reg == mcmf_pkg::ST_OUT) && go
                           && !xf_reg.pair && !sweep_more));
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next     = state_reg;
        cur_addr_next  = cur_addr_reg;
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = cur_addr_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;

        unique case (state_reg)
            mcmf_pkg::ST_IDLE:
            begin
                state_next = state_reg;
            end
            mcmf_pkg::ST_PROC:
            begin
                state_next = mcmf_pkg::ST_OUT;
            end
            mcmf_pkg::ST_OUT:
            begin
                if (go)
                begin
                    if (xf_reg.emit)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = xf_reg.res;
                        if (xf_reg.scaled)
                        begin
                            res_next.out_second = scaled_vol;
                        end
                    end
                    priority if (xf_reg.pair)
                    begin
                        state_next = mcmf_pkg::ST_EMIT2;
                    end
                    else if (sweep_more)
                    begin
                        cur_addr_next = cur_addr_reg + 1'b1;
                        tbl_rd_en     = 1'b1;
                        tbl_rd_addr   = cur_addr_next;
                        state_next    = mcmf_pkg::ST_PROC;
                    end
                    else
                    begin
                        state_next = mcmf_pkg::ST_IDLE;
                    end
                end
            end
            mcmf_pkg::ST_EMIT2:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_kind    = mcmf_pkg::KIND_CONTROL;
                    res_next.out_channel = item_reg.channel;
                    res_next.out_first   = mcmf_pkg::CTL_ALL_SOUNDS_OFF;
                    res_next.out_second  = 7'd0;
                    res_next.last        = 1'b1;
                    state_next           = mcmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcmf_pkg::ST_IDLE;
            end
        endcase

        // A set volume for all channels starts its sweep at channel 0.
        if (accept)
        begin
            if ((item.cmd == mcmf_pkg::CMD_VOLUME) && item.all_channels)
            begin
                cur_addr_next = '0;
            end
            else
            begin
                cur_addr_next = item.channel[CH_W-1:0];
            end
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = cur_addr_next;
            state_next  = mcmf_pkg::ST_PROC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcmf_pkg::ST_IDLE;
            cur_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_addr_reg  <= cur_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == mcmf_pkg::ST_PROC)
        begin
            xf_reg <= xf;
        end
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    // The table is written only in the transform cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> (state_reg == mcmf_pkg::ST_PROC))
        else $error("table write outside the transform cycle");

    // An accepted transfer always moves on to the transform cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mcmf_pkg::ST_PROC))
        else $error("accepted item did not reach the transform cycle");

    // The transform cycle is always followed by the output cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcmf_pkg::ST_PROC) |=> (state_reg == mcmf_pkg::ST_OUT))
        else $error("transform cycle not followed by output cycle");

    // The second result of a pair only comes from a mute command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcmf_pkg::ST_EMIT2) |-> (item_reg.cmd == mcmf_pkg::CMD_MUTE))
        else $error("pair result for a command other than mute");

    // No new item is taken while a channel sweep still has channels to go.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mcmf_pkg::ST_OUT) && sweep_more) |-> item_stall)
        else $error("item accepted in the middle of a channel sweep");
`endif

endmodule

// File: dv/midi_channel_message_filter_test.sv
// Self-checking testbench for the MIDI channel message filter: directed cases, a long
// receiver hold-off and random traffic, all checked against an in-file prediction.
// Depends on mcmf_pkg and midi_channel_message_filter from the rtl folder.
`timescale 1ns / 1ps

module midi_channel_message_filter_test;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 9;
    localparam int NUM_CHANNELS  = 16;
    // A set volume for every channel keeps the block busy while it sweeps all channels.
    localparam int SETTLE_CYCLES = 2 * NUM_CHANNELS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int FINAL_WAIT    = 5000;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 50;

    // Codes the package does not name.
    localparam logic [2:0] KIND_OTHER         = 3'd7;
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
    localparam logic [6:0] CTL_PAN            = 7'd10;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [6:0]        cfg_wr_data = 7'd0;
    logic              item_valid  = 1'b0;
    logic              item_stall;
    mcmf_pkg::item_t   item        = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    mcmf_pkg::result_t result;

    midi_channel_message_filter #(
        .CHANNELS (NUM_CHANNELS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // Predicted channel tables and pitch shift, mirroring the block after reset.
    logic              mute_tbl        [NUM_CHANNELS] = '{default: 1'b0};
    logic              lock_tbl        [NUM_CHANNELS] = '{default: 1'b0};
    logic [6:0]        locked_prog_tbl [NUM_CHANNELS] = '{default: 7'd0};
    logic [6:0]        last_prog_tbl   [NUM_CHANNELS] = '{default: 7'd0};
    logic [6:0]        main_vol_tbl    [NUM_CHANNELS] = '{default: 7'd100};
    logic [7:0]        vol_pct_tbl     [NUM_CHANNELS] = '{default: 8'd100};
    logic signed [6:0] semitone_shift = 7'sd0;

    mcmf_pkg::result_t emitted_msgs [$];
    int                mismatches   = 0;
    int                cycle_count  = 0;

    // Idling controls; each is written by the test sequence only.
    bit tx_jitter     = 1'b0;
    bit rx_jitter     = 1'b0;
    int hold_requests = 0;

    int holds_taken = 0;
    int hold_left   = 0;
    int burst_left  = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic logic [6:0] scaled_volume(input logic [6:0] value,
                                                 input logic [7:0] pct);
        int unsigned prod;
        prod = value * pct / 100;
        return (prod > mcmf_pkg::DATA_MAX) ? mcmf_pkg::DATA_MAX : prod[6:0];
    endfunction

    function automatic logic [6:0] shifted_key(input logic [3:0] ch, input logic [6:0] key);
        int k;
        int s;
        if (ch == mcmf_pkg::DRUM_CHANNEL)
            return key;
        k = key;
        s = semitone_shift;
        k = k + s;
        if (k < 0)
            k = 0;
        if (k > 127)
            k = 127;
        return k[6:0];
    endfunction

    function automatic mcmf_pkg::result_t control_msg(input logic [3:0] ch,
                                                      input logic [6:0] number,
                                                      input logic [6:0] value);
        mcmf_pkg::result_t r;
        r             = '0;
        r.out_kind    = mcmf_pkg::KIND_CONTROL;
        r.out_channel = ch;
        r.out_first   = number;
        r.out_second  = value;
        return r;
    endfunction

    // Applies one accepted transfer to the predicted tables and queues the messages
    // it causes, with last set on the final one.
    function automatic void filter_message(input mcmf_pkg::item_t it);
        mcmf_pkg::result_t batch [$];
        mcmf_pkg::result_t r;
        logic [3:0]        ch;
        logic [6:0]        prog;
        ch = it.channel;
        r  = '0;
        case (it.cmd)
            mcmf_pkg::CMD_MESSAGE:
            begin
                if (!mute_tbl[ch])
                begin
                    r.out_kind    = it.kind;
                    r.out_channel = ch;
                    r.out_first   = it.data_first;
                    r.out_second  = it.data_second;
                    case (it.kind)
                        mcmf_pkg::KIND_NOTEOFF, mcmf_pkg::KIND_NOTEON,
                        mcmf_pkg::KIND_KEYPRESS:
                        begin
                            r.out_first = shifted_key(ch, it.data_first);
                            batch.push_back(r);
                        end
                        mcmf_pkg::KIND_CONTROL:
                        begin
                            if (it.data_first == mcmf_pkg::CTL_MAIN_VOLUME)
                            begin
                                main_vol_tbl[ch] = it.data_second;
                                r.out_second = scaled_volume(it.data_second, vol_pct_tbl[ch]);
                            end
                            batch.push_back(r);
                        end
                        mcmf_pkg::KIND_PROGRAM:
                        begin
                            prog = lock_tbl[ch] ? locked_prog_tbl[ch] : it.data_first;
                            last_prog_tbl[ch] = prog;
                            r.out_first  = prog;
                            r.out_second = '0;
                            batch.push_back(r);
                        end
                        mcmf_pkg::KIND_CHANPRESS:
                        begin
                            r.out_second = '0;
                            batch.push_back(r);
                        end
                        mcmf_pkg::KIND_BEND:
                            batch.push_back(r);
                        default:
                            ;
                    endcase
                end
            end
            mcmf_pkg::CMD_MUTE:
            begin
                if (mute_tbl[ch] != it.enable)
                begin
                    if (it.enable)
                    begin
                        batch.push_back(control_msg(ch, mcmf_pkg::CTL_ALL_NOTES_OFF, '0));
                        batch.push_back(control_msg(ch, mcmf_pkg::CTL_ALL_SOUNDS_OFF, '0));
                    end
                    mute_tbl[ch] = it.enable;
                end
            end
            mcmf_pkg::CMD_LOCK:
            begin
                if (lock_tbl[ch] != it.enable)
                begin
                    lock_tbl[ch] = it.enable;
                    if (it.enable)
                        locked_prog_tbl[ch] = last_prog_tbl[ch];
                end
            end
            mcmf_pkg::CMD_PATCH:
            begin
                last_prog_tbl[ch] = it.patch;
                if (lock_tbl[ch])
                    locked_prog_tbl[ch] = it.patch;
            end
            mcmf_pkg::CMD_VOLUME:
            begin
                if (it.all_channels)
                begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        vol_pct_tbl[c] = it.volume_percent;
                        batch.push_back(control_msg(4'(c), mcmf_pkg::CTL_MAIN_VOLUME,
                            scaled_volume(main_vol_tbl[c], it.volume_percent)));
                    end
                end
                else
                begin
                    vol_pct_tbl[ch] = it.volume_percent;
                    batch.push_back(control_msg(ch, mcmf_pkg::CTL_MAIN_VOLUME,
                        scaled_volume(main_vol_tbl[ch], it.volume_percent)));
                end
            end
            default:
                ;
        endcase
        foreach (batch[i])
        begin
            r      = batch[i];
            r.last = (i == batch.size() - 1);
            emitted_msgs.push_back(r);
        end
    endfunction

    function automatic mcmf_pkg::item_t make_message(input logic [2:0] kind,
                                                     input logic [3:0] ch,
                                                     input logic [6:0] d1,
                                                     input logic [6:0] d2);
        mcmf_pkg::item_t it;
        it             = '0;
        it.cmd         = mcmf_pkg::CMD_MESSAGE;
        it.kind        = kind;
        it.channel     = ch;
        it.data_first  = d1;
        it.data_second = d2;
        return it;
    endfunction

    function automatic mcmf_pkg::item_t make_command(input logic [2:0] cmd,
                                                     input logic [3:0] ch,
                                                     input logic en,
                                                     input logic [6:0] patch_num,
                                                     input logic [7:0] pct,
                                                     input logic all);
        mcmf_pkg::item_t it;
        it                = '0;
        it.cmd            = cmd;
        it.channel        = ch;
        it.enable         = en;
        it.patch          = patch_num;
        it.volume_percent = pct;
        it.all_channels   = all;
        return it;
    endfunction

    // Mostly well-formed commands and messages with random content; a small share of
    // dropped kinds and reserved commands.
    function automatic mcmf_pkg::item_t random_item();
        logic [63:0]     bits;
        mcmf_pkg::item_t it;
        int unsigned     pick;
        bits = {$urandom, $urandom};
        it   = bits[$bits(mcmf_pkg::item_t)-1:0];
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            it.channel = mcmf_pkg::DRUM_CHANNEL;
        if (pick < 55)
        begin
            it.cmd  = mcmf_pkg::CMD_MESSAGE;
            it.kind = (pick < 2) ? KIND_OTHER
                    : 3'($urandom_range(mcmf_pkg::KIND_NOTEOFF, mcmf_pkg::KIND_BEND));
            if (it.kind == mcmf_pkg::KIND_CONTROL && $urandom_range(0, 1) == 1)
                it.data_first = mcmf_pkg::CTL_MAIN_VOLUME;
        end
        else if (pick < 67)
        begin
            it.cmd    = mcmf_pkg::CMD_MUTE;
            it.enable = ($urandom_range(0, 99) < 35);
        end
        else if (pick < 77)
            it.cmd = mcmf_pkg::CMD_LOCK;
        else if (pick < 85)
            it.cmd = mcmf_pkg::CMD_PATCH;
        else if (pick < 96)
        begin
            it.cmd          = mcmf_pkg::CMD_VOLUME;
            it.all_channels = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       it.volume_percent = 8'd0;
                1:       it.volume_percent = 8'd255;
                default: ;
            endcase
        end
        else
            it.cmd = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        return it;
    endfunction

    // Offers one transfer and returns at the edge that takes it. Valid is left high so
    // that back-to-back transfers never toggle it within one time step.
    task automatic send_item(input mcmf_pkg::item_t it);
        int gap;
        if (tx_jitter && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        filter_message(it);
    endtask

    // Stops offering and waits until every predicted message has come out, then lets
    // the block finish any work that produces nothing.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (emitted_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_shift(input logic [6:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        semitone_shift  = value;
    endtask

    task automatic test_reset_state();
        send_item(make_command(mcmf_pkg::CMD_VOLUME, 4'd0, 1'b0, 7'd0, 8'd100, 1'b1));
        send_item(make_message(mcmf_pkg::KIND_PROGRAM, 4'd4, 7'd33, 7'd127));
        wait_drained();
    endtask

    task automatic test_key_transpose();
        send_item(make_message(mcmf_pkg::KIND_NOTEON, 4'd0, 7'd0, 7'd127));
        write_shift(7'h40);
        send_item(make_message(mcmf_pkg::KIND_NOTEON, 4'd0, 7'd10, 7'd64));
        send_item(make_message(mcmf_pkg::KIND_NOTEON, mcmf_pkg::DRUM_CHANNEL, 7'd10, 7'd1));
        write_shift(7'd63);
        send_item(make_message(mcmf_pkg::KIND_NOTEOFF, 4'd1, 7'd127, 7'd0));
        send_item(make_message(mcmf_pkg::KIND_KEYPRESS, 4'd15, 7'd64, 7'd99));
        wait_drained();
    endtask

    task automatic test_controllers();
        send_item(make_message(mcmf_pkg::KIND_CONTROL, 4'd1,
                               mcmf_pkg::CTL_MAIN_VOLUME, 7'd127));
        send_item(make_command(mcmf_pkg::CMD_VOLUME, 4'd1, 1'b0, 7'd0, 8'd255, 1'b0));
        send_item(make_message(mcmf_pkg::KIND_CONTROL, 4'd1,
                               mcmf_pkg::CTL_MAIN_VOLUME, 7'd50));
        send_item(make_command(mcmf_pkg::CMD_VOLUME, 4'd1, 1'b0, 7'd0, 8'd0, 1'b0));
        send_item(make_message(mcmf_pkg::KIND_CONTROL, 4'd1, CTL_PAN, 7'd127));
        send_item(make_message(mcmf_pkg::KIND_BEND, 4'd2, 7'd127, 7'd127));
        send_item(make_message(mcmf_pkg::KIND_CHANPRESS, 4'd2, 7'd127, 7'd55));
        send_item(make_message(KIND_OTHER, 4'd2, 7'd1, 7'd2));
        wait_drained();
    endtask

    task automatic test_program_lock();
        send_item(make_message(mcmf_pkg::KIND_PROGRAM, 4'd2, 7'd5, 7'd0));
        send_item(make_command(mcmf_pkg::CMD_LOCK, 4'd2, 1'b1, 7'd0, 8'd0, 1'b0));
        send_item(make_message(mcmf_pkg::KIND_PROGRAM, 4'd2, 7'd9, 7'd0));
        send_item(make_command(mcmf_pkg::CMD_PATCH, 4'd2, 1'b0, 7'd77, 8'd0, 1'b0));
        send_item(make_message(mcmf_pkg::KIND_PROGRAM, 4'd2, 7'd1, 7'd0));
        send_item(make_command(mcmf_pkg::CMD_LOCK, 4'd2, 1'b0, 7'd0, 8'd0, 1'b0));
        send_item(make_command(mcmf_pkg::CMD_LOCK, 4'd2, 1'b0, 7'd0, 8'd0, 1'b0));
        wait_drained();
    endtask

    task automatic test_mute();
        send_item(make_command(mcmf_pkg::CMD_MUTE, 4'd3, 1'b1, 7'd0, 8'd0, 1'b0));
        send_item(make_command(mcmf_pkg::CMD_MUTE, 4'd3, 1'b1, 7'd0, 8'd0, 1'b0));
        send_item(make_message(mcmf_pkg::KIND_NOTEON, 4'd3, 7'd60, 7'd100));
        send_item(make_command(mcmf_pkg::CMD_MUTE, 4'd3, 1'b0, 7'd0, 8'd0, 1'b0));
        send_item(make_command(mcmf_pkg::CMD_MUTE, 4'd3, 1'b0, 7'd0, 8'd0, 1'b0));
        wait_drained();
    endtask

    task automatic test_reserved_commands();
        for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
            send_item(make_command(3'(c), 4'd5, 1'b1, 7'd127, 8'd255, 1'b1));
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills up
    // and stalls its input.
    task automatic test_backpressure();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        hold_requests++;
        repeat (40)
            send_item(make_command(mcmf_pkg::CMD_VOLUME, 4'($urandom_range(0, 15)), 1'b0,
                                   7'd0, 8'($urandom_range(0, 255)),
                                   ($urandom_range(0, 7) == 0)));
        wait_drained();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    task automatic test_random_traffic();
        mcmf_pkg::item_t it;
        int              counted;
        int              phase_len;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_shift(7'($urandom_range(0, 127)));
                1:       write_shift(7'h40);
                2:       write_shift(7'd63);
                default:
                begin
                    write_shift(7'd0);
                    // Quiet finish: no idling on either side.
                    tx_jitter = 1'b0;
                    rx_jitter = 1'b0;
                end
            endcase
            phase_len = (phase == 3) ? 60 : 100;
            counted   = 0;
            while (counted < phase_len)
            begin
                it = random_item();
                send_item(it);
                if (it.cmd <= mcmf_pkg::CMD_VOLUME
                    && !(it.cmd == mcmf_pkg::CMD_MESSAGE && it.kind == KIND_OTHER))
                    counted++;
            end
        end
    endtask

    // Receiver side: a long hold-off when the test asks for one, otherwise random
    // stall bursts while jitter is on.
    always @(posedge clk)
    begin
        if (hold_requests != holds_taken)
        begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            result_stall <= 1'b1;
        end
        else if (rx_jitter && $urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(0, 9);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Every result transfer is matched against the oldest predicted message.
    always @(posedge clk)
    begin : compare_results
        mcmf_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (emitted_msgs.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d channel %0d",
                                          result.out_kind, result.out_channel));
            else
            begin
                want = emitted_msgs.pop_front();
                if (result.out_kind !== want.out_kind)
                    report_mismatch($sformatf("out_kind got %0d want %0d",
                                              result.out_kind, want.out_kind));
                if (result.out_channel !== want.out_channel)
                    report_mismatch($sformatf("out_channel got %0d want %0d",
                                              result.out_channel, want.out_channel));
                if (result.out_first !== want.out_first)
                    report_mismatch($sformatf("out_first got %0d want %0d",
                                              result.out_first, want.out_first));
                if (result.out_second !== want.out_second)
                    report_mismatch($sformatf("out_second got %0d want %0d",
                                              result.out_second, want.out_second));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d",
                                              result.last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** midi_channel_message_filter: FAILED **");
            $finish;
        end
    end

    initial
    begin : run
        int waited;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;

        test_reset_state();
        test_key_transpose();
        test_controllers();
        test_program_lock();
        test_mute();
        test_reserved_commands();
        test_backpressure();
        test_random_traffic();

        item_valid <= 1'b0;
        waited = 0;
        while (emitted_msgs.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (emitted_msgs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", emitted_msgs.size()));

        if (mismatches == 0)
            $display("** midi_channel_message_filter: PASSED **");
        else
            $display("** midi_channel_message_filter: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/mcmf_pkg.sv
rtl/mcmf_table.sv
rtl/mcmf_xform.sv
rtl/midi_channel_message_filter.sv
dv/midi_channel_message_filter_test.sv
